@@ rtl/ctt_pkg.sv @@
`default_nettype none

package ctt_pkg;

   // calendar constants
   localparam int unsigned BASE_YEAR     = 1984;
   localparam int unsigned YEAR_SPAN     = 178;
   localparam int unsigned MS_PER_HOUR   = 3600000;
   localparam int unsigned MS_PER_MINUTE = 60000;
   localparam int unsigned MS_PER_SECOND = 1000;

   // field widths
   localparam int unsigned YEAR_W  = 12;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned HOUR_W  = 5;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned SEC_W   = 6;
   localparam int unsigned TICK_W  = 64;
   localparam int unsigned DCNT_W  = 16;
   localparam int unsigned MSEC_W  = 27;
   localparam int unsigned YIDX_W  = $clog2(YEAR_SPAN + 1);
   localparam int unsigned MDAY_W  = 9;

   // config register widths and indexes
   localparam int unsigned EPOCH_W = 63;
   localparam int unsigned TPD_W   = 40;
   localparam int unsigned TPM_W   = 27;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_EPOCH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TPD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TPM   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN   = 3'd5;

   localparam logic [EPOCH_W-1:0] EPOCH_RST = 63'd625773600000000000;
   localparam logic [TPD_W-1:0]   TPD_RST   = 40'd864000000000;
   localparam logic [TPM_W-1:0]   TPM_RST   = 27'd10000;
   localparam logic [TICK_W-1:0]  MASK_RST  = 64'd4611686018427387903;
   localparam logic [TICK_W-1:0]  MAX_RST   = 64'd3155378975999999999;
   localparam logic [TICK_W-1:0]  MIN_RST   = 64'd0;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [TPD_W-1:0]   tpd;
      logic [TPM_W-1:0]   tpm;
      logic [TICK_W-1:0]  mask;
      logic [TICK_W-1:0]  max;
      logic [TICK_W-1:0]  min;
   } cfg_type;

   // one classified item: whole days and milliseconds since midnight
   typedef struct packed {
      logic [DCNT_W-1:0] days;
      logic [MSEC_W-1:0] msec;
   } work_type;

   // per year offset: {leap, days from base year start to this year start}
   typedef logic [YEAR_SPAN:0][DCNT_W:0] year_table_type;

   function automatic year_table_type build_year_table();
      year_table_type tbl;
      int unsigned    days;
      int unsigned    y;
      logic           lp;
      days = 0;
      for (int unsigned i = 0; i <= YEAR_SPAN; i++) begin
         y  = BASE_YEAR + i;
         lp = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
         tbl[i] = {lp, days[DCNT_W-1:0]};
         days = days + 365 + (lp ? 1 : 0);
      end
      return tbl;
   endfunction

   localparam year_table_type YEAR_TABLE = build_year_table();

   // days before the month; zero acts as january, past twelve is the full year
   function automatic logic [MDAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
      logic [MDAY_W-1:0] d;
      case (m)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd365;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

@@ rtl/calendar_to_tick_count.sv @@
// calendar time to 64-bit tick count
// pipeline: an accepted item is registered in turn by the queue write, multiply, add and range
//   check stages, and the result strobe rises together with the range-checked result
// throughput: one item per cycle; the back drains the queue every cycle, so it never
//   holds more than one item and busy stays low
// reset (synchronous, active high) empties the queue and pipeline and loads
//   the config registers with their defaults; the receiver cannot stall
`default_nettype none

module calendar_to_tick_count #(
   parameter int unsigned QUEUE_DEPTH = ctt_pkg::QUEUE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // item input
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [ctt_pkg::YEAR_W-1:0]      req_year,
   input  wire logic [ctt_pkg::MONTH_W-1:0]     req_month,
   input  wire logic [ctt_pkg::DAY_W-1:0]       req_day,
   input  wire logic [ctt_pkg::HOUR_W-1:0]      req_hour,
   input  wire logic [ctt_pkg::MIN_W-1:0]       req_minute,
   input  wire logic [ctt_pkg::SEC_W-1:0]       req_second,
   // result output
   output logic                                 rsp_valid,
   output logic [ctt_pkg::TICK_W-1:0]           rsp_ticks,
   // config writes
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ctt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ctt_pkg::TICK_W-1:0]      csr_wdata
);

   ctt_pkg::cfg_type  cfg_ff, cfg_in;
   ctt_pkg::work_type front_work;
   ctt_pkg::work_type queue_work;
   logic              accept;
   logic              q_empty;
   logic              q_full;
   logic              csr_write;

   // config registers, always ready; each write truncated to its register width
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            ctt_pkg::CSR_EPOCH: cfg_in.epoch = csr_wdata[ctt_pkg::EPOCH_W-1:0];
            ctt_pkg::CSR_TPD:   cfg_in.tpd   = csr_wdata[ctt_pkg::TPD_W-1:0];
            ctt_pkg::CSR_TPM:   cfg_in.tpm   = csr_wdata[ctt_pkg::TPM_W-1:0];
            ctt_pkg::CSR_MASK:  cfg_in.mask  = csr_wdata;
            ctt_pkg::CSR_MAX:   cfg_in.max   = csr_wdata;
            ctt_pkg::CSR_MIN:   cfg_in.min   = csr_wdata;
            default:            cfg_in       = cfg_ff;   // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.epoch <= ctt_pkg::EPOCH_RST;
         cfg_ff.tpd   <= ctt_pkg::TPD_RST;
         cfg_ff.tpm   <= ctt_pkg::TPM_RST;
         cfg_ff.mask  <= ctt_pkg::MASK_RST;
         cfg_ff.max   <= ctt_pkg::MAX_RST;
         cfg_ff.min   <= ctt_pkg::MIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: clamps the year, looks up days to year start, adds month/day,
   // and folds hour/minute/second into milliseconds
   assign busy   = q_full;
   assign accept = start && !busy;

   ctt_front u_front (
      .year   (req_year),
      .month  (req_month),
      .day    (req_day),
      .hour   (req_hour),
      .minute (req_minute),
      .second (req_second),
      .work   (front_work)
   );

   // short queue between front and back; back drains one item per cycle
   ctt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_work),
      .pop       (!q_empty),
      .pop_data  (queue_work),
      .empty     (q_empty),
      .full      (q_full)
   );

   // back: multiply by tick rates, sum with the epoch, range check
   ctt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_work   (queue_work),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .out_ticks (rsp_ticks)
   );

endmodule

`default_nettype wire

@@ rtl/ctt_front.sv @@
`default_nettype none

module ctt_front (
   input  wire logic [ctt_pkg::YEAR_W-1:0]  year,
   input  wire logic [ctt_pkg::MONTH_W-1:0] month,
   input  wire logic [ctt_pkg::DAY_W-1:0]   day,
   input  wire logic [ctt_pkg::HOUR_W-1:0]  hour,
   input  wire logic [ctt_pkg::MIN_W-1:0]   minute,
   input  wire logic [ctt_pkg::SEC_W-1:0]   second,
   output ctt_pkg::work_type                work
);

   localparam logic [ctt_pkg::YEAR_W-1:0] YEAR_LO =
      ctt_pkg::YEAR_W'(ctt_pkg::BASE_YEAR);
   localparam logic [ctt_pkg::YEAR_W-1:0] YEAR_HI =
      ctt_pkg::YEAR_W'(ctt_pkg::BASE_YEAR + ctt_pkg::YEAR_SPAN);

   logic [ctt_pkg::YIDX_W-1:0] yidx;
   logic [ctt_pkg::DCNT_W:0]   yentry;
   logic                       leap_add;
   logic [ctt_pkg::DAY_W-1:0]  day_off;
   logic [ctt_pkg::MSEC_W-1:0] ms_h;
   logic [ctt_pkg::MSEC_W-1:0] ms_m;
   logic [ctt_pkg::MSEC_W-1:0] ms_s;

   // clamp year into the table
   always_comb begin
      if (year < YEAR_LO) begin
         yidx = '0;
      end else if (year > YEAR_HI) begin
         yidx = ctt_pkg::YIDX_W'(ctt_pkg::YEAR_SPAN);
      end else begin
         yidx = ctt_pkg::YIDX_W'(year - YEAR_LO);
      end
   end

   assign yentry   = ctt_pkg::YEAR_TABLE[yidx];
   assign leap_add = yentry[ctt_pkg::DCNT_W] && (month > 4'd2);
   assign day_off  = (day == '0) ? '0 : day - 5'd1;

   assign work.days = yentry[ctt_pkg::DCNT_W-1:0]
                    + ctt_pkg::DCNT_W'(ctt_pkg::month_days(month))
                    + ctt_pkg::DCNT_W'(leap_add)
                    + ctt_pkg::DCNT_W'(day_off);

   assign ms_h = ctt_pkg::MSEC_W'(hour)   * ctt_pkg::MSEC_W'(ctt_pkg::MS_PER_HOUR);
   assign ms_m = ctt_pkg::MSEC_W'(minute) * ctt_pkg::MSEC_W'(ctt_pkg::MS_PER_MINUTE);
   assign ms_s = ctt_pkg::MSEC_W'(second) * ctt_pkg::MSEC_W'(ctt_pkg::MS_PER_SECOND);
   assign work.msec = ms_h + ms_m + ms_s;

endmodule

`default_nettype wire

@@ rtl/ctt_queue.sv @@
`default_nettype none

module ctt_queue #(
   parameter int unsigned DEPTH = ctt_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ctt_pkg::work_type push_data,
   input  wire logic              pop,
   output ctt_pkg::work_type      pop_data,
   output logic                   empty,
   output logic                   full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ctt_pkg::work_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff,  count_in;
   logic                do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_FULL);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ctt_back.sv @@
`default_nettype none

module ctt_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire ctt_pkg::work_type           in_work,
   input  wire ctt_pkg::cfg_type            cfg,
   output logic                             out_valid,
   output logic [ctt_pkg::TICK_W-1:0]       out_ticks
);

   localparam int unsigned W = ctt_pkg::TICK_W;

   logic         s1_valid_ff;
   logic [W-1:0] day_prod_ff, day_prod_in;
   logic [W-1:0] ms_prod_ff,  ms_prod_in;
   logic         s2_valid_ff;
   logic [W-1:0] sum_ff, sum_in;
   logic         s3_valid_ff;
   logic [W-1:0] ticks_ff, ticks_in;

   // multiply stage
   assign day_prod_in = W'(cfg.tpd) * W'(in_work.days);
   assign ms_prod_in  = W'(cfg.tpm) * W'(in_work.msec);

   // add stage, wraps mod 2^64
   assign sum_in = W'(cfg.epoch) + day_prod_ff + ms_prod_ff;

   // range check
   assign ticks_in = ((sum_ff & cfg.mask) > cfg.max) ? cfg.min : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      day_prod_ff <= day_prod_in;
      ms_prod_ff  <= ms_prod_in;
      sum_ff      <= sum_in;
      ticks_ff    <= ticks_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_ticks = ticks_ff;

endmodule

`default_nettype wire
